FILE: rtl/ccs_pkg.sv
// Shared types and constants for the charge current solver
`timescale 1ns / 1ps
`default_nettype none
package ccs_pkg;

  // Discriminant width: V*V (32b) + 4*R*(dP) (16+2+21 signed) -> 41b signed.
  localparam int DISC_W = 41;
  localparam int SQRT_W = 20;
  // Numerator of the current divisions: 1000*(s-v), with |s-v| < 2^21.
  localparam int NUM_W  = 32;
  localparam int QUO_W  = 32;
  localparam int DEN_W  = 17;

  // x/1000 for any 32-bit x: (x * RECIP_1000) >> RECIP_SH
  localparam logic [28:0] RECIP_1000 = 29'h10624DD3;
  localparam int          RECIP_SH   = 38;

  localparam logic [1:0] MODE_CC  = 2'd0;
  localparam logic [1:0] MODE_CV  = 2'd1;
  localparam logic [1:0] MODE_NAT = 2'd2;

  localparam logic [1:0] REG_RES = 2'd0;
  localparam logic [1:0] REG_ICC = 2'd1;
  localparam logic [1:0] REG_VCV = 2'd2;

  // Item context carried along the pipeline.
  typedef struct packed {
    logic        vld;
    logic [15:0] v;
    logic [15:0] r;
    logic [15:0] icc;
    logic [15:0] vcv;
    logic        deficit;
  } ctx_t;

  // Square root cell payload.
  typedef struct packed {
    logic [DISC_W-1:0] x;
    logic [DISC_W-1:0] res;
  } sq_t;

  // Divider cell payload (magnitudes; signs tracked separately).
  typedef struct packed {
    logic [NUM_W-1:0] rem_num;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] den;
    logic             neg;
  } dv_t;

  // Drop the valid flag of an item context while kill is high
  function automatic ctx_t ctx_kill(ctx_t c, logic kill);
    ctx_t o;
    o = c;
    if (kill) o.vld = 1'b0;
    return o;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cc_cv_charge_current_solver.sv
// Top level: pipelined CC/CV charge current solver
// Pipeline: the discriminant register, the square root cells, the numerator
// registers, the divider cells, then the select and scale registers.
// Throughput: one item per cycle; the chains of square root and divider
// cells each hold one item per cell. busy never rises.
// Reset: synchronous rst restores R=100, Icc=1000, Vcv=8400 and drops all
// items in flight. The receiver cannot stall; strobe marks each result.
`timescale 1ns / 1ps
`default_nettype none
module cc_cv_charge_current_solver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] battery_voltage,
  input  wire logic [19:0] generated_power,
  input  wire logic [19:0] load_power,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             strobe,
  output logic signed [20:0] charge_current,
  output logic [16:0]      bus_level,
  output logic [1:0]       charge_mode,
  output logic             power_deficit
);
  localparam int SQ_N = ccs_pkg::SQRT_W + 1;
  localparam int DV_N = ccs_pkg::QUO_W;

  logic [15:0] r_reg, icc_reg, vcv_reg;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      r_reg   <= 16'd100;
      icc_reg <= 16'd1000;
      vcv_reg <= 16'd8400;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ccs_pkg::REG_RES: r_reg   <= cfg_data;
        ccs_pkg::REG_ICC: icc_reg <= cfg_data;
        ccs_pkg::REG_VCV: vcv_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 0: form the discriminant
  logic [15:0] r_eff;
  logic [31:0] vsq;
  logic signed [20:0] dpow;
  logic signed [ccs_pkg::DISC_W-1:0] pterm;
  logic signed [ccs_pkg::DISC_W-1:0] disc;
  ccs_pkg::ctx_t c0;
  ccs_pkg::sq_t  s0;
  assign r_eff = (r_reg == 16'd0) ? 16'd1 : r_reg;
  assign vsq   = 32'(battery_voltage) * 32'(battery_voltage);
  assign dpow  = $signed({1'b0, generated_power}) - $signed({1'b0, load_power});
  assign pterm = $signed({1'b0, r_eff, 2'b0}) * dpow;
  assign disc  = $signed({9'b0, vsq}) + pterm;
  always_ff @(posedge clk) begin
    if (rst) c0.vld <= 1'b0;
    else     c0.vld <= start;
    c0.v       <= battery_voltage;
    c0.r       <= r_eff;
    c0.icc     <= icc_reg;
    c0.vcv     <= vcv_reg;
    c0.deficit <= disc[ccs_pkg::DISC_W-1];
    s0.x       <= disc[ccs_pkg::DISC_W-1] ? '0 : disc;
    s0.res     <= '0;
  end

  // Square root chain
  ccs_pkg::sq_t  sq [SQ_N+1];
  ccs_pkg::ctx_t sc [SQ_N+1];
  assign sq[0] = s0;
  assign sc[0] = c0;
  for (genvar g = 0; g < SQ_N; g++) begin : g_sq
    ccs_sqrt_cell #(.BIT_POS(SQ_N - 1 - g)) u_cell (
      .clk(clk), .rst(rst), .din(sq[g]), .cin(sc[g]), .dout(sq[g+1]), .cout(sc[g+1])
    );
  end

  // Stage A: differences for the natural and CV numerators (s-v, vcv-v)
  ccs_pkg::ctx_t ca;
  logic signed [22:0] dn_a, dc_a;
  always_ff @(posedge clk) begin
    ca   <= ccs_pkg::ctx_kill(sc[SQ_N], rst);
    dn_a <= $signed({2'b0, sq[SQ_N].res[20:0]}) - $signed({7'b0, sc[SQ_N].v});
    dc_a <= $signed({7'b0, sc[SQ_N].vcv}) - $signed({7'b0, sc[SQ_N].v});
  end

  ccs_pkg::ctx_t cb;
  ccs_pkg::dv_t  db;
  logic signed [32:0] tb;
  logic signed [32:0] pn, pc;
  assign pn = 33'(dn_a) * 33'sd1000;
  assign pc = 33'(dc_a) * 33'sd1000;
  // Stage B: launch both divisions (natural /2R, CV /R);
  // the CV numerator is held in tb for the second chain
  always_ff @(posedge clk) begin
    cb <= ccs_pkg::ctx_kill(ca, rst);
    db.neg     <= pn[32];
    db.rem_num <= pn[32] ? 32'(-pn) : pn[31:0];
    db.quo     <= '0;
    db.den     <= {ca.r, 1'b0};
    tb         <= pc;
  end

  // Divider chain for the natural current
  ccs_pkg::dv_t  dv [DV_N+1];
  ccs_pkg::ctx_t dc [DV_N+1];
  assign dv[0] = db;
  assign dc[0] = cb;
  for (genvar g = 0; g < DV_N; g++) begin : g_dv
    ccs_div_cell #(.BIT_POS(DV_N - 1 - g)) u_cell (
      .clk(clk), .rst(rst), .din(dv[g]), .cin(dc[g]),
      .dout(dv[g+1]), .cout(dc[g+1])
    );
  end

  // Second chain for the CV current (divide by R)
  ccs_pkg::dv_t  ev [DV_N+1];
  ccs_pkg::ctx_t ec [DV_N+1];
  ccs_pkg::dv_t  eb;
  logic signed [32:0] pcs;
  assign pcs = tb;
  always_comb begin
    eb.neg     = pcs[32];
    eb.rem_num = pcs[32] ? 32'(-pcs) : pcs[31:0];
    eb.quo     = '0;
    eb.den     = {1'b0, cb.r};
  end
  assign ev[0] = eb;
  assign ec[0] = cb;
  for (genvar g = 0; g < DV_N; g++) begin : g_ev
    ccs_div_cell #(.BIT_POS(DV_N - 1 - g)) u_cell (
      .clk(clk), .rst(rst), .din(ev[g]), .cin(ec[g]),
      .dout(ev[g+1]), .cout(ec[g+1])
    );
  end

  // Stage C: signed quotients
  ccs_pkg::ctx_t cc;
  logic signed [33:0] inat, icv;
  always_ff @(posedge clk) begin
    cc <= ccs_pkg::ctx_kill(dc[DV_N], rst);
    inat <= dv[DV_N].neg ? -$signed({2'b0, dv[DV_N].quo}) : $signed({2'b0, dv[DV_N].quo});
    icv  <= ev[DV_N].neg ? -$signed({2'b0, ev[DV_N].quo}) : $signed({2'b0, ev[DV_N].quo});
  end

  // Stage D: R*I products for the mode comparisons, registered
  ccs_pkg::ctx_t cd;
  logic signed [50:0] rn, ric;
  logic signed [33:0] inat_d, icv_d;
  always_ff @(posedge clk) begin
    cd <= ccs_pkg::ctx_kill(cc, rst);
    rn  <= $signed({1'b0, cc.r}) * inat;
    ric <= $signed({1'b0, cc.r}) * $signed({18'b0, cc.icc});
    inat_d <= inat;
    icv_d  <= icv;
  end

  // Stage E: choose mode and current
  ccs_pkg::ctx_t ce;
  logic signed [33:0] cur_e;
  logic [1:0] mode_e, mode_n;
  logic signed [33:0] cur_n;
  logic signed [51:0] lim, v1000;
  always_comb begin
    v1000 = 52'($signed({1'b0, cd.v})) * 52'sd1000;
    lim   = 52'($signed({1'b0, cd.vcv})) * 52'sd1000;
    if (inat_d >= $signed({18'b0, cd.icc})) begin
      if (v1000 + 52'(ric) < lim) begin
        mode_n = ccs_pkg::MODE_CC; cur_n = $signed({18'b0, cd.icc});
      end else begin
        mode_n = ccs_pkg::MODE_CV; cur_n = icv_d;
      end
    end else begin
      if (v1000 + 52'(rn) < lim) begin
        mode_n = ccs_pkg::MODE_NAT; cur_n = inat_d;
      end else begin
        mode_n = ccs_pkg::MODE_CV; cur_n = icv_d;
      end
    end
  end
  always_ff @(posedge clk) begin
    ce <= ccs_pkg::ctx_kill(cd, rst);
    cur_e  <= cur_n;
    mode_e <= mode_n;
  end

  // Stage F: R*I for the bus voltage
  ccs_pkg::ctx_t cf;
  logic signed [50:0] ri_f;
  logic signed [33:0] cur_f;
  logic [1:0] mode_f;
  always_ff @(posedge clk) begin
    cf <= ccs_pkg::ctx_kill(ce, rst);
    ri_f   <= $signed({1'b0, ce.r}) * cur_e;
    cur_f  <= cur_e;
    mode_f <= mode_e;
  end

  // Stage F2: multiply |R*I| (below 2^32) by the reciprocal of 1000
  ccs_pkg::ctx_t cg;
  logic [31:0] ri_mag;
  logic [60:0] ri_prod;
  logic        ri_neg;
  logic signed [33:0] cur_g;
  logic [1:0] mode_g;
  assign ri_mag = ri_f[50] ? 32'(-ri_f) : ri_f[31:0];
  always_ff @(posedge clk) begin
    cg <= ccs_pkg::ctx_kill(cf, rst);
    ri_prod <= 61'(ri_mag) * 61'(ccs_pkg::RECIP_1000);
    ri_neg  <= ri_f[50];
    cur_g   <= cur_f;
    mode_g  <= mode_f;
  end

  // Stage G: apply the sign, add V, clamp and present
  logic [22:0] bus_q;
  logic signed [51:0] bus_s;
  assign bus_q = ri_prod[60:ccs_pkg::RECIP_SH];
  assign bus_s = ri_neg ? $signed({36'b0, cg.v}) - $signed({29'b0, bus_q})
                        : $signed({36'b0, cg.v}) + $signed({29'b0, bus_q});
  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= cg.vld;
    if (cur_g > 34'sd1048575)       charge_current <= 21'sd1048575;
    else if (cur_g < -34'sd1048576) charge_current <= -21'sd1048576;
    else                            charge_current <= cur_g[20:0];
    if (bus_s < 0)                  bus_level <= '0;
    else if (bus_s > 52'sd131071)   bus_level <= 17'd131071;
    else                            bus_level <= bus_s[16:0];
    charge_mode   <= mode_g;
    power_deficit <= cg.deficit;
  end
endmodule
`default_nettype wire

FILE: rtl/ccs_sqrt_cell.sv
// One step of the digit-by-digit floor square root
`timescale 1ns / 1ps
`default_nettype none
module ccs_sqrt_cell #(
  parameter int BIT_POS = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ccs_pkg::sq_t    din,
  input  wire ccs_pkg::ctx_t   cin,
  output ccs_pkg::sq_t         dout,
  output ccs_pkg::ctx_t        cout
);
  localparam logic [ccs_pkg::DISC_W-1:0] BITV =
    ccs_pkg::DISC_W'(1) << (2 * BIT_POS);

  logic [ccs_pkg::DISC_W-1:0] trial;
  ccs_pkg::sq_t nxt;

  // Try subtracting res+bit, keep the remainder when it fits
  always_comb begin
    trial = din.res + BITV;
    if (din.x >= trial) begin
      nxt.x   = din.x - trial;
      nxt.res = (din.res >> 1) + BITV;
    end else begin
      nxt.x   = din.x;
      nxt.res = din.res >> 1;
    end
  end

  // Hand on to the next cell, drop the item on reset
  always_ff @(posedge clk) begin
    dout <= nxt;
    cout <= ccs_pkg::ctx_kill(cin, rst);
  end
endmodule
`default_nettype wire

FILE: rtl/ccs_div_cell.sv
// One restoring division step producing one quotient bit
`timescale 1ns / 1ps
`default_nettype none
module ccs_div_cell #(
  parameter int BIT_POS = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ccs_pkg::dv_t      din,
  input  wire ccs_pkg::ctx_t     cin,
  output ccs_pkg::dv_t           dout,
  output ccs_pkg::ctx_t          cout
);
  logic [ccs_pkg::NUM_W+ccs_pkg::DEN_W-1:0] sh;
  ccs_pkg::dv_t nxt;

  // Subtract den<<BIT_POS when the remainder allows
  always_comb begin
    nxt = din;
    sh  = {{ccs_pkg::NUM_W{1'b0}}, din.den} << BIT_POS;
    if ({{ccs_pkg::DEN_W{1'b0}}, din.rem_num} >= sh) begin
      nxt.rem_num = din.rem_num - sh[ccs_pkg::NUM_W-1:0];
      nxt.quo[BIT_POS] = 1'b1;
    end
  end

  // Hand on to the next cell, drop the item on reset
  always_ff @(posedge clk) begin
    dout <= nxt;
    cout <= ccs_pkg::ctx_kill(cin, rst);
  end
endmodule
`default_nettype wire
